/* design/dpd_pkg.sv */
// shared types and constants for the detection proposal decoder
package dpd_pkg;

   localparam int MAX_CLASSES = 256;
   localparam int CLASS_CNT_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int CLASS_ID_W  = 8;
   localparam int SCORE_W     = 17;
   localparam int COORD_W     = 16;
   localparam int SCALE_W     = 16;
   localparam int DELTA_W     = COORD_W + 2;
   localparam int MAG_W       = COORD_W + 1;
   localparam int EDGE_PROD_W = MAG_W + SCALE_W;
   localparam int SIZE_PROD_W = COORD_W + SCALE_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_SCORE_THRESHOLD = 2'd0,
      REG_SCALE_X         = 2'd1,
      REG_SCALE_Y         = 2'd2
   } reg_index_type;

   localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 17'd16384;
   localparam logic [SCALE_W-1:0] SCALE_RESET     = 16'd4096;

   typedef struct packed {
      logic [SCORE_W-1:0] class_score;
      logic               last_class;
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic [COORD_W-1:0] box_width;
      logic [COORD_W-1:0] box_height;
   } req_payload_type;

   typedef struct packed {
      logic [CLASS_ID_W-1:0]    class_index;
      logic [SCORE_W-1:0]       confidence;
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic [COORD_W-1:0]       width_px;
      logic [COORD_W-1:0]       height_px;
   } rsp_payload_type;

   // a proposal that passed the threshold, box still in model space
   typedef struct packed {
      logic [CLASS_ID_W-1:0]     class_index;
      logic [SCORE_W-1:0]        confidence;
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic [COORD_W-1:0]        box_width;
      logic [COORD_W-1:0]        box_height;
   } proposal_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score_threshold;
      logic [SCALE_W-1:0] scale_x;
      logic [SCALE_W-1:0] scale_y;
   } config_type;

endpackage

/* design/dpd_channels.sv */
// valid/ready channel interfaces for request and response transfers
interface dpd_req_if;
   import dpd_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface dpd_rsp_if;
   import dpd_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* design/dpd_front.sv */
// front end: running best class per proposal and threshold decision
module dpd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   input  dpd_pkg::req_payload_type     item,
   input  logic [dpd_pkg::SCORE_W-1:0]  score_threshold,
   output logic                         push_valid,
   output dpd_pkg::proposal_type        push_data
);
   import dpd_pkg::*;

   logic [SCORE_W-1:0]     best_score_ff, best_score_in;
   logic [CLASS_CNT_W-1:0] best_class_ff, best_class_in;
   logic [CLASS_CNT_W-1:0] class_counter_ff, class_counter_in;
   logic                   wins;
   logic [SCORE_W-1:0]     cur_score;
   logic [CLASS_CNT_W-1:0] cur_class;
   logic [CLASS_CNT_W-1:0] counter_next;

   always_comb begin
      wins      = item.class_score > best_score_ff;
      cur_score = wins ? item.class_score : best_score_ff;
      cur_class = wins ? class_counter_ff : best_class_ff;
      if (class_counter_ff == CLASS_CNT_W'(MAX_CLASSES - 1)) begin
         counter_next = '0;
      end else begin
         counter_next = class_counter_ff + 1'b1;
      end

      best_score_in    = best_score_ff;
      best_class_in    = best_class_ff;
      class_counter_in = class_counter_ff;
      if (item_valid) begin
         if (item.last_class) begin
            best_score_in    = '0;
            best_class_in    = '0;
            class_counter_in = '0;
         end else begin
            best_score_in    = cur_score;
            best_class_in    = cur_class;
            class_counter_in = counter_next;
         end
      end

      push_valid = item_valid && item.last_class && (cur_score > score_threshold);
      push_data.class_index = CLASS_ID_W'(cur_class);
      push_data.confidence  = cur_score;
      // 2*c - w is c - w/2 with one extra fraction bit
      push_data.delta_x    = {1'b0, item.center_x, 1'b0} - DELTA_W'(item.box_width);
      push_data.delta_y    = {1'b0, item.center_y, 1'b0} - DELTA_W'(item.box_height);
      push_data.box_width  = item.box_width;
      push_data.box_height = item.box_height;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff    <= '0;
         best_class_ff    <= '0;
         class_counter_ff <= '0;
      end else begin
         best_score_ff    <= best_score_in;
         best_class_ff    <= best_class_in;
         class_counter_ff <= class_counter_in;
      end
   end

endmodule

/* design/dpd_queue.sv */
// short queue of accepted proposals between front and back
module dpd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  dpd_pkg::proposal_type push_data,
   output logic                  full,
   output logic                  head_valid,
   output dpd_pkg::proposal_type head_data,
   input  logic                  pop
);
   import dpd_pkg::*;

   proposal_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      full       = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
      head_valid = count_ff != '0;
      head_data  = entry_ff[rd_ptr_ff];
      do_push    = push_valid && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = do_push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && full))
      else $error("proposal pushed into a full queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_pop_only_drains: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count not reduced on pop");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");
`endif

endmodule

/* design/dpd_back.sv */
// back end: box scaling to frame pixels, saturation and output register
module dpd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  dpd_pkg::config_type   cfg,
   input  logic                  head_valid,
   input  dpd_pkg::proposal_type head_data,
   output logic                  pop,
   output logic                  out_valid,
   output dpd_pkg::rsp_payload_type out_data,
   input  logic                  out_ready
);
   import dpd_pkg::*;

   // multiply stage
   logic                    s1_valid_ff, s1_valid_in;
   logic [CLASS_ID_W-1:0]   s1_class_ff;
   logic [SCORE_W-1:0]      s1_conf_ff;
   logic                    s1_neg_x_ff, s1_neg_y_ff;
   logic [EDGE_PROD_W-1:0]  s1_prod_x_ff, s1_prod_y_ff;
   logic [SIZE_PROD_W-1:0]  s1_prod_w_ff, s1_prod_h_ff;
   // output stage
   logic                    out_valid_ff, out_valid_in;
   rsp_payload_type         out_data_ff, out_data_in;

   logic                    out_adv;
   logic                    s1_adv;
   logic [MAG_W-1:0]        mag_x, mag_y;

   function automatic logic [COORD_W-1:0] sat_edge(input logic neg,
                                                   input logic [COORD_W-1:0] q);
      logic [COORD_W-1:0] lim;
      lim = {1'b1, {(COORD_W-1){1'b0}}};
      if (neg) begin
         return (q > lim) ? lim : (~q + 1'b1);
      end
      return (q > (lim - 1'b1)) ? (lim - 1'b1) : q;
   endfunction

   always_comb begin
      out_adv      = !out_valid_ff || out_ready;
      s1_adv       = !s1_valid_ff || out_adv;
      pop          = s1_adv && head_valid;
      s1_valid_in  = s1_adv ? head_valid : s1_valid_ff;
      out_valid_in = out_adv ? s1_valid_ff : out_valid_ff;

      mag_x = head_data.delta_x[DELTA_W-1] ? MAG_W'(-head_data.delta_x)
                                           : MAG_W'(head_data.delta_x);
      mag_y = head_data.delta_y[DELTA_W-1] ? MAG_W'(-head_data.delta_y)
                                           : MAG_W'(head_data.delta_y);

      out_data_in.class_index = s1_class_ff;
      out_data_in.confidence  = s1_conf_ff;
      out_data_in.left       = sat_edge(s1_neg_x_ff,
                                        s1_prod_x_ff[EDGE_PROD_W-1 -: COORD_W]);
      out_data_in.top        = sat_edge(s1_neg_y_ff,
                                        s1_prod_y_ff[EDGE_PROD_W-1 -: COORD_W]);
      // a 16 by 16 bit product shifted down by 16 always fits
      out_data_in.width_px   = s1_prod_w_ff[SIZE_PROD_W-1 -: COORD_W];
      out_data_in.height_px  = s1_prod_h_ff[SIZE_PROD_W-1 -: COORD_W];

      out_valid = out_valid_ff;
      out_data  = out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_class_ff  <= head_data.class_index;
         s1_conf_ff   <= head_data.confidence;
         s1_neg_x_ff  <= head_data.delta_x[DELTA_W-1];
         s1_neg_y_ff  <= head_data.delta_y[DELTA_W-1];
         s1_prod_x_ff <= mag_x * cfg.scale_x;
         s1_prod_y_ff <= mag_y * cfg.scale_y;
         s1_prod_w_ff <= head_data.box_width * cfg.scale_x;
         s1_prod_h_ff <= head_data.box_height * cfg.scale_y;
      end
      if (out_adv) begin
         out_data_ff <= out_data_in;
      end
   end

`ifndef SYNTHESIS
   a_s1_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_adv) |=> (s1_valid_ff && $stable(s1_conf_ff)))
      else $error("multiply stage lost its proposal under stall");
   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!s1_valid_ff || out_adv))
      else $error("queue popped with multiply stage blocked");
   a_out_from_s1: assert property (@(posedge clock) disable iff (reset)
      ($rose(out_valid_ff)) |-> $past(s1_valid_ff))
      else $error("result appeared without a proposal behind it");
`endif

endmodule

/* design/detection_proposal_decoder.sv */
// top level of the detection proposal decoder with its register port
// Takes one class score per transfer on req_chan, one every cycle, proposal by
// proposal; the front keeps the running best score and class and on the last
// score of a proposal decides against score_threshold in the same cycle. Passing
// proposals go through a four-entry queue to the back, which scales the box with
// one multiply stage and one saturating output register; results pass from the
// queue through these registers to rsp_chan and can leave one per cycle while
// rsp_chan is ready. req_chan stalls only when the queue is full. Registers are
// written over the APB-style port (threshold at 0x0, scale_x at 0x4, scale_y at 0x8).
module detection_proposal_decoder (
   input  logic                          clock,
   input  logic                          reset,
   dpd_req_if.sink                       req_chan,
   dpd_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [dpd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [dpd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [dpd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import dpd_pkg::*;

   config_type    cfg_ff, cfg_in;
   reg_index_type reg_sel;
   logic          csr_write;
   logic          item_valid;
   logic          push_valid;
   proposal_type  push_data;
   logic          queue_full;
   logic          head_valid;
   proposal_type  head_data;
   logic          pop;

   always_comb begin
      pready    = 1'b1;
      reg_sel   = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
      csr_write = psel && penable && pwrite && pready;
      cfg_in    = cfg_ff;
      prdata    = '0;
      case (reg_sel)
         REG_SCORE_THRESHOLD: begin
            prdata = CSR_DATA_W'(cfg_ff.score_threshold);
            if (csr_write) begin
               cfg_in.score_threshold = pwdata[SCORE_W-1:0];
            end
         end
         REG_SCALE_X: begin
            prdata = CSR_DATA_W'(cfg_ff.scale_x);
            if (csr_write) begin
               cfg_in.scale_x = pwdata[SCALE_W-1:0];
            end
         end
         REG_SCALE_Y: begin
            prdata = CSR_DATA_W'(cfg_ff.scale_y);
            if (csr_write) begin
               cfg_in.scale_y = pwdata[SCALE_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase

      req_chan.ready = !queue_full;
      item_valid     = req_chan.valid && !queue_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_threshold <= THRESHOLD_RESET;
         cfg_ff.scale_x         <= SCALE_RESET;
         cfg_ff.scale_y         <= SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dpd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item            (req_chan.payload),
      .score_threshold (cfg_ff.score_threshold),
      .push_valid      (push_valid),
      .push_data       (push_data)
   );

   dpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   dpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .out_valid  (rsp_chan.valid),
      .out_data   (rsp_chan.payload),
      .out_ready  (rsp_chan.ready)
   );

endmodule

/* tb/sv/dpd_result_checker.sv */
// checker for the detection proposal decoder: watches transfers and register writes, predicts boxes
module dpd_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   dpd_req_if                             req_mon,
   dpd_rsp_if                             rsp_mon,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [dpd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [dpd_pkg::CSR_DATA_W-1:0] pwdata,
   output int                             mismatches,
   output int                             outstanding
);
   import dpd_pkg::*;

   config_type               cfg;
   logic [SCORE_W-1:0]       best_score;
   logic [CLASS_ID_W-1:0]    best_class;
   logic [CLASS_CNT_W-1:0]   class_idx;
   rsp_payload_type          expected_boxes[$];

   // trunc toward zero of delta*scale/2^17, clamped to signed 16 bit
   function automatic logic [COORD_W-1:0] frame_corner(longint delta, logic [SCALE_W-1:0] scale);
      longint unsigned mag;
      longint unsigned q;
      mag = (delta < 0) ? longint'(-delta) : longint'(delta);
      q = (mag * scale) >> 17;
      if (delta < 0) begin
         return (q > 32768) ? 16'h8000 : COORD_W'(-q);
      end
      return (q > 32767) ? 16'h7FFF : COORD_W'(q);
   endfunction

   function automatic logic [COORD_W-1:0] frame_size(logic [COORD_W-1:0] size,
                                                     logic [SCALE_W-1:0] scale);
      longint unsigned q;
      q = (longint'(size) * scale) >> 16;
      return (q > 65535) ? 16'hFFFF : COORD_W'(q);
   endfunction

   function automatic void take_score(req_payload_type item);
      rsp_payload_type box;
      // strictly greater wins, so the earlier class keeps a tie
      if (item.class_score > best_score) begin
         best_score = item.class_score;
         best_class = CLASS_ID_W'(class_idx);
      end
      class_idx = (class_idx == CLASS_CNT_W'(MAX_CLASSES - 1)) ? '0 : class_idx + 1'b1;
      if (item.last_class) begin
         if (best_score > cfg.score_threshold) begin
            box.class_index = best_class;
            box.confidence  = best_score;
            box.left       = frame_corner(2 * longint'(item.center_x) - longint'(item.box_width),
                                          cfg.scale_x);
            box.top        = frame_corner(2 * longint'(item.center_y) - longint'(item.box_height),
                                          cfg.scale_y);
            box.width_px   = frame_size(item.box_width, cfg.scale_x);
            box.height_px  = frame_size(item.box_height, cfg.scale_y);
            expected_boxes = {expected_boxes, box};
         end
         best_score = '0;
         best_class = '0;
         class_idx  = '0;
      end
   endfunction

   function automatic void check_field(string field, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_box(rsp_payload_type got);
      rsp_payload_type want;
      if (expected_boxes.size() == 0) begin
         $error("unexpected result transfer: class_index %0d confidence %0d",
                got.class_index, got.confidence);
         mismatches++;
         return;
      end
      want = expected_boxes.pop_front();
      check_field("class_index", want.class_index, got.class_index);
      check_field("confidence", want.confidence, got.confidence);
      check_field("left", $signed(want.left), $signed(got.left));
      check_field("top", $signed(want.top), $signed(got.top));
      check_field("width_px", want.width_px, got.width_px);
      check_field("height_px", want.height_px, got.height_px);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.score_threshold = THRESHOLD_RESET;
         cfg.scale_x         = SCALE_RESET;
         cfg.scale_y         = SCALE_RESET;
         best_score          = '0;
         best_class          = '0;
         class_idx           = '0;
         expected_boxes.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[CSR_ADDR_W-1:2]))
               REG_SCORE_THRESHOLD: cfg.score_threshold = pwdata[SCORE_W-1:0];
               REG_SCALE_X:         cfg.scale_x = pwdata[SCALE_W-1:0];
               REG_SCALE_Y:         cfg.scale_y = pwdata[SCALE_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            take_score(req_mon.payload);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_box(rsp_mon.payload);
         end
      end
      outstanding <= expected_boxes.size();
   end

endmodule

/* tb/sv/tb_detection_proposal_decoder.sv */
// testbench top for the detection proposal decoder: clock, reset, stimulus and verdict
module tb_detection_proposal_decoder;
   import dpd_pkg::*;

   localparam int CLOCK_HALF       = 6;
   localparam int RUN_LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int END_WAIT_LIMIT   = 5000;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int PRESSURE_ITEMS   = 16;
   localparam int RANDOM_ITEMS     = 1650;
   localparam int PHASES           = 8;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatches;
   int                    outstanding;
   int                    items_sent;
   bit                    sender_bursty;
   bit                    receiver_bursty;
   bit                    hold_request;

   dpd_req_if req_chan ();
   dpd_rsp_if rsp_chan ();

   detection_proposal_decoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   dpd_result_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      #(2 * CLOCK_HALF * RUN_LIMIT_CYCLES);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 17'd65536;
         2:       return SCORE_W'($urandom_range(65537, 131071));
         3:       return ($urandom_range(0, 1) != 0) ? 17'd20000 : 17'd40000;
         default: return SCORE_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 16'hFFFF;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic int pick_class_count();
      case ($urandom_range(0, 9))
         0:       return 1;
         8, 9:    return $urandom_range(9, 40);
         default: return $urandom_range(2, 8);
      endcase
   endfunction

   task automatic send_score(logic [SCORE_W-1:0] score, logic last,
                             logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                             logic [COORD_W-1:0] bw, logic [COORD_W-1:0] bh);
      int              gap;
      req_payload_type item;
      gap = sender_bursty ? 0 : $urandom_range(0, 8);
      item.class_score = score;
      item.last_class  = last;
      item.center_x    = cx;
      item.center_y    = cy;
      item.box_width   = bw;
      item.box_height  = bh;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.payload <= item;
      req_chan.valid   <= 1'b1;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      items_sent++;
   endtask

   task automatic send_random_proposal(int count);
      if ($urandom_range(0, 15) == 0) sender_bursty = !sender_bursty;
      for (int k = 0; k < count; k++) begin
         send_score(pick_score(), k == count - 1, pick_coord(), pick_coord(), pick_coord(),
                    pick_coord());
      end
   endtask

   // more scores than class indices, the winner sitting past the wrap
   task automatic send_wrapping_proposal();
      int count;
      int winner;
      count  = MAX_CLASSES + $urandom_range(2, 20);
      winner = MAX_CLASSES + $urandom_range(0, count - MAX_CLASSES - 1);
      for (int k = 0; k < count; k++) begin
         send_score((k == winner) ? SCORE_W'($urandom_range(60000, 131071))
                                  : SCORE_W'($urandom_range(0, 59999)),
                    k == count - 1, pick_coord(), pick_coord(), pick_coord(), pick_coord());
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(reg_index_type index, logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({index, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(int threshold, int scale_x, int scale_y);
      drain();
      write_register(REG_SCORE_THRESHOLD, CSR_DATA_W'(threshold));
      write_register(REG_SCALE_X, CSR_DATA_W'(scale_x));
      write_register(REG_SCALE_Y, CSR_DATA_W'(scale_y));
   endtask

   // result side: random hold-offs per transfer, bursty stretches and one long stall
   initial begin : result_sink
      int hold;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (!receiver_bursty) begin
            hold = $urandom_range(0, 8);
            if (hold != 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (hold) @(posedge clock);
            end
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         if ($urandom_range(0, 31) == 0) receiver_bursty = !receiver_bursty;
      end
   end

   initial begin : stimulus
      int phase_end;
      int waited;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: full-scale score, box at the corners
      send_score(17'd65536, 1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
      // all scores zero
      send_score(17'd0, 1'b0, 16'h1234, 16'h1234, 16'h0100, 16'h0100);
      send_score(17'd0, 1'b0, 16'h1234, 16'h1234, 16'h0100, 16'h0100);
      send_score(17'd0, 1'b1, 16'h1234, 16'h1234, 16'h0100, 16'h0100);
      // tie keeps the first class
      send_score(17'd30000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_score(17'd50000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_score(17'd50000, 1'b1, 16'h0800, 16'h0400, 16'h0200, 16'h0100);
      // exactly at threshold is dropped, one above passes
      send_score(17'd16384, 1'b1, 16'h0800, 16'h0800, 16'h0100, 16'h0100);
      send_score(17'd16385, 1'b1, 16'h0800, 16'h0800, 16'h0100, 16'h0100);
      // score beyond 1.0, left box edge negative
      send_score(17'd100, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_score(17'd131071, 1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);

      apply_settings(0, 65535, 65535);
      // zero best score never beats even a zero threshold
      send_score(17'd0, 1'b1, 16'h4000, 16'h4000, 16'h1000, 16'h1000);
      // left edge saturates
      send_score(17'd1, 1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
      send_score(17'd5, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_score(17'd5, 1'b1, pick_coord(), pick_coord(), pick_coord(), pick_coord());

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       apply_settings(THRESHOLD_RESET, SCALE_RESET, SCALE_RESET);
            1:       apply_settings(0, 65535, 65535);
            2:       apply_settings(65536, 0, 65535);
            3:       apply_settings(131071, 4096, 0);
            4:       apply_settings(1, 8192, 2048);
            default: apply_settings($urandom_range(0, 70000), $urandom_range(0, 65535),
                                    $urandom_range(0, 65535));
         endcase
         phase_end = items_sent + RANDOM_ITEMS / PHASES;
         if (phase == 1) begin
            // hold results back while single-score proposals keep coming
            sender_bursty = 1'b1;
            hold_request  = 1'b1;
            for (int k = 0; k < PRESSURE_ITEMS; k++) begin
               send_score(SCORE_W'($urandom_range(1, 131071)), 1'b1, pick_coord(),
                          pick_coord(), pick_coord(), pick_coord());
            end
            sender_bursty = 1'b0;
            send_wrapping_proposal();
         end
         while (items_sent < phase_end) send_random_proposal(pick_class_count());
      end

      req_chan.valid <= 1'b0;
      waited = 0;
      @(posedge clock);
      while (outstanding != 0 && waited < END_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (outstanding != 0) $error("%0d expected results never arrived", outstanding);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
